// ===== rtl/core/double_to_exact_decimal_core_assert.svh =====
// Assertion macros shared by the checker of double_to_exact_decimal_core.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef DOUBLE_TO_EXACT_DECIMAL_CORE_ASSERT_SVH
`define DOUBLE_TO_EXACT_DECIMAL_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define D2ED_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define D2ED_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/d2ed_pkg.sv =====
// Package for the double-to-exact-decimal core: field widths, constants,
// the front-to-back descriptor type and the back-end state type. No dependencies.
`timescale 1ns / 1ps

package d2ed_pkg;

  localparam int FRAC_BITS_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam int MANT_W  = 52;
  localparam int EXP_W   = 11;
  localparam int UEXP_W  = 12;
  localparam int INT_W   = 64;
  localparam int DIGIT_W = 4;

  localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;
  localparam int               INT_MAX_EXP = 63;

  // Single: one result with no digit (zero, no fraction, out of range).
  // Digits: a non-zero fraction that is expanded digit by digit.
  typedef enum logic {
    K_SINGLE,
    K_DIGITS
  } kind_t;

  typedef struct packed {
    logic               sign;
    logic [UEXP_W-1:0]  uexp;
    logic [MANT_W-1:0]  mant;
    logic [INT_W-1:0]   intp;
    logic               rerr;
    kind_t              kind;
  } desc_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } bstate_t;

endpackage

// ===== rtl/core/d2ed_front.sv =====
// Front end: accepts a binary64 pattern, classifies it and forms the integer
// part and the left-aligned binary fraction. Depends on d2ed_pkg.
`timescale 1ns / 1ps

module d2ed_front import d2ed_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          float_bits,
  input  logic                 q_full,
  output logic                 q_push,
  output desc_t                desc,
  output logic [FRAC_BITS-1:0] frac
);

  localparam int SHW = $clog2(FRAC_BITS);
  localparam logic signed [12:0] EMIN = 13'(52 - FRAC_BITS);
  localparam logic signed [12:0] EMAX = 13'(INT_MAX_EXP);
  localparam logic signed [12:0] EPT  = 13'(MANT_W);

  logic [EXP_W-1:0]          expf;
  logic signed [12:0]        e_s;
  logic signed [12:0]        sh_full;
  logic [SHW-1:0]            sh;
  logic [MANT_W:0]           sig;
  logic [FRAC_BITS+MANT_W:0] wide;
  logic                      is_zero;
  logic                      is_range;
  logic [INT_W-1:0]          int_lo;
  logic [INT_W-1:0]          int_hi;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    expf     = float_bits[62:52];
    e_s      = $signed({2'b00, expf}) - $signed({2'b00, EXP_BIAS});
    sig      = {1'b1, float_bits[MANT_W-1:0]};
    is_zero  = (float_bits[62:0] == 63'd0);
    is_range = (e_s < EMIN) || (e_s > EMAX);

    // Fraction bits scaled by 2^FRAC_BITS; the shift stays below FRAC_BITS in range.
    sh_full = e_s + 13'(FRAC_BITS - MANT_W);
    sh      = sh_full[SHW-1:0];
    wide    = {{FRAC_BITS{1'b0}}, sig} << sh;

    int_lo = INT_W'(sig) >> (6'd52 - e_s[5:0]);
    int_hi = INT_W'(sig) << (e_s[5:0] - 6'd52);

    desc.sign = float_bits[63];
    desc.uexp = e_s[UEXP_W-1:0];
    desc.mant = float_bits[MANT_W-1:0];
    desc.rerr = 1'b0;
    desc.kind = K_SINGLE;
    desc.intp = '0;
    frac      = '0;

    priority if (is_zero) begin
      desc.kind = K_SINGLE;
    end else if (is_range) begin
      desc.rerr = 1'b1;
    end else if (e_s >= EPT) begin
      desc.intp = int_hi;
    end else begin
      desc.intp = e_s[12] ? '0 : int_lo;
      frac      = wide[FRAC_BITS-1:0];
      desc.kind = (wide[FRAC_BITS-1:0] == '0) ? K_SINGLE : K_DIGITS;
    end
  end

endmodule

// ===== rtl/core/d2ed_queue.sv =====
// Short register queue between front and back ends.
// Depends on d2ed_pkg for the default depth.
`timescale 1ns / 1ps

module d2ed_queue import d2ed_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/d2ed_back.sv =====
// Back end: takes descriptors from the queue, emits single results directly and
// expands fractions by repeated times-ten, one digit per cycle when not stalled. Depends on d2ed_pkg.
`timescale 1ns / 1ps

module d2ed_back import d2ed_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  desc_t                q_desc,
  input  logic [FRAC_BITS-1:0] q_frac,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 sign_bit,
  output logic [UEXP_W-1:0]    unbiased_exponent,
  output logic [MANT_W-1:0]    mantissa_field,
  output logic [INT_W-1:0]     integer_part,
  output logic [DIGIT_W-1:0]   decimal_digit,
  output logic                 digit_valid,
  output logic                 last_result,
  output logic                 range_error
);

  bstate_t                       state;
  bstate_t                       state_next;
  desc_t                         hdr;
  logic [FRAC_BITS-1:0]          frac;
  logic [FRAC_BITS+DIGIT_W-1:0]  prod;
  logic [FRAC_BITS-1:0]          frac_next;
  logic                          adv;
  logic                          emit;
  logic                          single;

  // x*10 = x*8 + x*2; the top nibble is the carry-out digit.
  assign prod      = ({{DIGIT_W{1'b0}}, frac} << 3) + ({{DIGIT_W{1'b0}}, frac} << 1);
  assign frac_next = prod[FRAC_BITS-1:0];
  assign adv       = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    single     = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && adv) begin
          q_pop = 1'b1;
          if (q_desc.kind == K_DIGITS) begin
            state_next = B_RUN;
          end else begin
            single = 1'b1;
          end
        end
      end
      B_RUN: begin
        if (adv) begin
          emit = 1'b1;
          if (frac_next == '0) begin
            state_next = B_IDLE;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (single || emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hdr  <= q_desc;
      frac <= q_frac;
    end else if (emit) begin
      frac <= frac_next;
    end
    if (single) begin
      sign_bit          <= q_desc.sign;
      unbiased_exponent <= q_desc.uexp;
      mantissa_field    <= q_desc.mant;
      integer_part      <= q_desc.intp;
      decimal_digit     <= '0;
      digit_valid       <= 1'b0;
      last_result       <= 1'b1;
      range_error       <= q_desc.rerr;
    end else if (emit) begin
      sign_bit          <= hdr.sign;
      unbiased_exponent <= hdr.uexp;
      mantissa_field    <= hdr.mant;
      integer_part      <= hdr.intp;
      decimal_digit     <= prod[FRAC_BITS+DIGIT_W-1:FRAC_BITS];
      digit_valid       <= 1'b1;
      last_result       <= (frac_next == '0);
      range_error       <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/double_to_exact_decimal_core.sv =====
// Exact decimal expansion of a binary64 value. A digitless result passes through the queue
// and the output register; the first digit of a fraction also through the fraction register.
// Unless stalled, a fraction gives one digit per cycle down to its lowest set bit (at most FRAC_BITS digits).
// Back end: a digitless item goes straight to the output register; a fraction is loaded first; stalls hold both.
// The 2-entry queue lets the front take new items while the back end is still emitting.
// Reset (rst, synchronous, active high) empties the queue, idles the back end and drops out_valid.
`timescale 1ns / 1ps

module double_to_exact_decimal_core import d2ed_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [63:0]         float_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                sign_bit,
  output logic [UEXP_W-1:0]   unbiased_exponent,
  output logic [MANT_W-1:0]   mantissa_field,
  output logic [INT_W-1:0]    integer_part,
  output logic [DIGIT_W-1:0]  decimal_digit,
  output logic                digit_valid,
  output logic                last_result,
  output logic                range_error
);

  // Queue entry: fraction in the top bits, descriptor below.
  localparam int DW = FRAC_BITS + $bits(desc_t);

  desc_t                f_desc;
  logic [FRAC_BITS-1:0] f_frac;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  logic [DW-1:0]        q_rd;
  desc_t                b_desc;
  logic [FRAC_BITS-1:0] b_frac;

  // Front: classification is combinational, straight into the queue on transfer.
  d2ed_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .float_bits (float_bits),
    .q_full     (q_full),
    .q_push     (q_push),
    .desc       (f_desc),
    .frac       (f_frac)
  );

  d2ed_queue #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_frac, f_desc}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .empty     (q_empty)
  );

  assign b_desc = q_rd[$bits(desc_t)-1:0];
  assign b_frac = q_rd[DW-1:$bits(desc_t)];

  // Back: one digit per cycle from the times-ten adder while not stalled, held in an output register.
  d2ed_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_desc            (b_desc),
    .q_frac            (b_frac),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sign_bit          (sign_bit),
    .unbiased_exponent (unbiased_exponent),
    .mantissa_field    (mantissa_field),
    .integer_part      (integer_part),
    .decimal_digit     (decimal_digit),
    .digit_valid       (digit_valid),
    .last_result       (last_result),
    .range_error       (range_error)
  );

endmodule

// ===== rtl/core/d2ed_checker.sv =====
// Port-level checker for double_to_exact_decimal_core, bound to the top level.
// Depends on d2ed_pkg and double_to_exact_decimal_core_assert.svh.
`timescale 1ns / 1ps
`include "double_to_exact_decimal_core_assert.svh"

module d2ed_checker import d2ed_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [INT_W-1:0]   integer_part,
  input logic [DIGIT_W-1:0] decimal_digit,
  input logic               digit_valid,
  input logic               last_result,
  input logic               range_error
);

  `D2ED_ASSERT_NOW(a_digit_decimal, out_valid && digit_valid, decimal_digit <= 4'd9, "digit above nine")
  `D2ED_ASSERT_NOW(a_range_single, out_valid && range_error, last_result && !digit_valid && integer_part == '0, "range result malformed")
  `D2ED_ASSERT_NOW(a_nodigit_last, out_valid && !digit_valid, last_result, "digitless result not last")
  `D2ED_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(decimal_digit) && $stable(last_result), "stalled result changed")

endmodule

bind double_to_exact_decimal_core d2ed_checker u_d2ed_checker (.*);
